[rtl/yph_pkg.sv]
package yph_pkg;

    // Serial multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 48;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Serial divider widths: dividend magnitude and time step divisor
    localparam int DIV_N_W = 49;
    localparam int DIV_D_W = 20;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // Wide accumulator for the throttle sum
    localparam int ACC_W = 66;

    localparam logic [16:0] THR_ONE = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_YAW,
        ST_MUL_IE,
        ST_DIV,
        ST_MUL_KP,
        ST_MUL_KI,
        ST_MUL_KD,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_YAW_GAIN       = 3'd0,
        REG_MAX_YAW_RATE   = 3'd1,
        REG_HOVER_THROTTLE = 3'd2,
        REG_HEIGHT_KP      = 3'd3,
        REG_HEIGHT_KI      = 3'd4,
        REG_HEIGHT_KD      = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        CMD_UPDATE   = 1'b0,
        CMD_SET_GOAL = 1'b1
    } cmd_t;

    // Handshake status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Saturate a wide signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(48'sh7FFF_FFFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return 48'sh7FFF_FFFF_FFFF;
        else if (v < lo)
            return 48'sh8000_0000_0000;
        else
            return v[47:0];
    endfunction

endpackage

[rtl/yph_mul.sv]
module yph_mul
    import yph_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [MUL_A_W-1:0]   op_a,
    input  logic signed [MUL_B_W-1:0]   op_b,
    output logic signed [MUL_P_W-1:0]   product,
    output unit_sts_t                   sts
);

    logic [MUL_P_W-1:0]        prod_reg;
    logic [MUL_P_W-1:0]        prod_next;
    logic signed [MUL_A_W-1:0] a_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      last;
    logic signed [MUL_A_W:0]   hi;
    logic signed [MUL_A_W:0]   sum;

    // One multiplier bit per cycle; the sign bit of op_b subtracts
    always_comb
    begin
        last = (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));
        hi   = (MUL_A_W + 1)'(signed'(prod_reg[MUL_P_W-1:MUL_B_W]));
        if (!prod_reg[0])
            sum = hi;
        else if (last)
            sum = hi - (MUL_A_W + 1)'(a_reg);
        else
            sum = hi + (MUL_A_W + 1)'(a_reg);
        prod_next = {sum, prod_reg[MUL_B_W-1:1]};
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial product shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= op_a;
            prod_reg <= {{MUL_A_W{1'b0}}, op_b};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product  = prod_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

[rtl/yph_div.sv]
module yph_div
    import yph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_N_W-1:0]   num,
    input  logic [DIV_D_W-1:0]   den,
    output logic [DIV_N_W-1:0]   quo,
    output unit_sts_t            sts
);

    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 last;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W+1:0]   diff;
    logic                 borrow;

    // Restoring division, one quotient bit per cycle
    always_comb
    begin
        last   = (cnt_reg == DIV_CNT_W'(DIV_N_W - 1));
        trial  = {rem_reg, quo_reg[DIV_N_W-1]};
        diff   = {1'b0, trial} - {2'b00, den_reg};
        borrow = diff[DIV_D_W+1];
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift dividend out and quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= borrow ? trial[DIV_D_W-1:0] : diff[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ~borrow};
        end
    end

    assign quo      = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

[rtl/yaw_p_height_pid_controller_unit.sv]
// Yaw P and height PID controller, Q16.16. A set-goal item (tuser high) stores
// the four setpoints, clears the integral and last error and gives no result.
// An update item runs five products on a shared bit-serial 33x48 multiplier
// and, when a derivative is due, a bit-serial divide by the time step as well.
// ST_FINISH closes the throttle and ST_OUT loads the output register. One item
// is worked on at a time; a finished result waits in the output register while
// the next item is taken. A new result waits for that register to empty.
// Configuration writes are taken in every cycle (cfg_ready is tied high);
// indexes 6 and 7 are ignored.
module yaw_p_height_pid_controller_unit
    import yph_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    // Input stream
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [215:0]   s_tdata,   // meas_yaw, meas_height, time_step, goal_pitch,
                                      // goal_roll, goal_yaw, goal_height, zero pad
    input  logic           s_tuser,   // cmd
    // Result stream
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [119:0]   m_tdata,   // out_pitch, out_roll, out_yaw_rate,
                                      // out_throttle, zero pad
    // Configuration writes
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic signed [31:0] yaw_gain_reg;
    logic        [30:0] max_yaw_rate_reg;
    logic        [16:0] hover_reg;
    logic signed [31:0] kp_reg;
    logic signed [31:0] ki_reg;
    logic signed [31:0] kd_reg;

    logic signed [31:0] sp_pitch_reg;
    logic signed [31:0] sp_roll_reg;
    logic signed [31:0] sp_yaw_reg;
    logic signed [31:0] sp_height_reg;
    logic signed [47:0] integral_reg;
    logic signed [31:0] last_err_reg;
    logic               first_reg;

    logic signed [31:0]      e_reg;
    logic [DIV_D_W-1:0]      dt_reg;
    logic                    neg_reg;
    logic signed [31:0]      d_reg;
    logic signed [31:0]      yaw_cmd_reg;
    logic [16:0]             thr_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [119:0]            m_tdata_reg;
    logic                    m_tvalid_reg;

    logic signed [31:0] in_meas_yaw;
    logic signed [31:0] in_meas_height;
    logic [19:0]        in_dt;
    logic               accept;
    logic               skip_d;
    logic               out_free;

    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;
    unit_sts_t                 mul_sts;
    logic signed [MUL_P_W-17:0] mul_q16;

    logic                div_start;
    logic [DIV_N_W-1:0]  div_num;
    logic [DIV_N_W-1:0]  div_quo;
    unit_sts_t           div_sts;
    logic signed [32:0]  err_diff;
    logic [32:0]         err_mag;
    logic signed [DIV_N_W:0] d_signed;

    logic signed [ACC_W-1:0] yaw_v;
    logic signed [ACC_W-1:0] yaw_max;
    logic signed [31:0]      yaw_clamped;
    logic signed [47:0]      desired;
    logic [16:0]             thr;
    logic signed [ACC_W-1:0] excess;
    logic signed [47:0]      int_after;

    assign in_meas_yaw    = s_tdata[31:0];
    assign in_meas_height = s_tdata[63:32];
    assign in_dt          = s_tdata[83:64];

    assign accept   = s_tvalid && s_tready;
    assign skip_d   = first_reg || (dt_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign mul_q16  = mul_prod[MUL_P_W-1:16];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && (s_tuser == CMD_UPDATE))
                    state_next = ST_MUL_YAW;
            ST_MUL_YAW:
                if (mul_sts.done)
                    state_next = ST_MUL_IE;
            ST_MUL_IE:
                if (mul_sts.done)
                    state_next = skip_d ? ST_MUL_KP : ST_DIV;
            ST_DIV:
                if (div_sts.done)
                    state_next = ST_MUL_KP;
            ST_MUL_KP:
                if (mul_sts.done)
                    state_next = ST_MUL_KI;
            ST_MUL_KI:
                if (mul_sts.done)
                    state_next = ST_MUL_KD;
            ST_MUL_KD:
                if (mul_sts.done)
                    state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Unit launches and operand selection
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        err_diff  = 33'(e_reg) - 33'(last_err_reg);
        err_mag   = err_diff[32] ? 33'(-err_diff) : 33'(err_diff);
        div_num   = {err_mag, 16'h0000};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == CMD_UPDATE))
                begin
                    mul_start = 1'b1;
                    mul_a     = 33'(sp_yaw_reg) - 33'(in_meas_yaw);
                    mul_b     = MUL_B_W'(yaw_gain_reg);
                end
            end
            ST_MUL_YAW:
            begin
                mul_start = mul_sts.done;
                mul_a     = 33'(e_reg);
                mul_b     = MUL_B_W'({1'b0, dt_reg});
            end
            ST_MUL_IE:
            begin
                mul_start = mul_sts.done && skip_d;
                div_start = mul_sts.done && !skip_d;
                mul_a     = 33'(e_reg);
                mul_b     = MUL_B_W'(kp_reg);
            end
            ST_DIV:
            begin
                mul_start = div_sts.done;
                mul_a     = 33'(e_reg);
                mul_b     = MUL_B_W'(kp_reg);
            end
            ST_MUL_KP:
            begin
                mul_start = mul_sts.done;
                mul_a     = 33'(ki_reg);
                mul_b     = integral_reg;
            end
            ST_MUL_KI:
            begin
                mul_start = mul_sts.done;
                mul_a     = 33'(d_reg);
                mul_b     = MUL_B_W'(kd_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Clamps and the closing throttle and anti-windup arithmetic
    always_comb
    begin
        yaw_v   = ACC_W'(mul_q16);
        yaw_max = ACC_W'({1'b0, max_yaw_rate_reg});
        if (yaw_v > yaw_max)
            yaw_clamped = 32'(yaw_max);
        else if (yaw_v < -yaw_max)
            yaw_clamped = 32'(-yaw_max);
        else
            yaw_clamped = yaw_v[31:0];

        d_signed = neg_reg ? -(DIV_N_W + 1)'({1'b0, div_quo})
                           : (DIV_N_W + 1)'({1'b0, div_quo});

        desired = sat48(acc_reg);
        if (desired[47])
            thr = '0;
        else if (desired > 48'(THR_ONE))
            thr = THR_ONE;
        else
            thr = desired[16:0];
        excess    = ACC_W'(desired) - ACC_W'({1'b0, thr});
        int_after = sat48(ACC_W'(integral_reg) - (excess <<< 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_gain_reg     <= '0;
            max_yaw_rate_reg <= '0;
            hover_reg        <= '0;
            kp_reg           <= '0;
            ki_reg           <= '0;
            kd_reg           <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_YAW_GAIN:       yaw_gain_reg     <= cfg_data;
                REG_MAX_YAW_RATE:   max_yaw_rate_reg <= cfg_data[30:0];
                REG_HOVER_THROTTLE: hover_reg        <= cfg_data[16:0];
                REG_HEIGHT_KP:      kp_reg           <= cfg_data;
                REG_HEIGHT_KI:      ki_reg           <= cfg_data;
                REG_HEIGHT_KD:      kd_reg           <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Controller state: setpoints, integral, last error, first-step flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_pitch_reg  <= '0;
            sp_roll_reg   <= '0;
            sp_yaw_reg    <= '0;
            sp_height_reg <= '0;
            integral_reg  <= '0;
            last_err_reg  <= '0;
            first_reg     <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (accept && (s_tuser == CMD_SET_GOAL))
            begin
                sp_pitch_reg  <= s_tdata[115:84];
                sp_roll_reg   <= s_tdata[147:116];
                sp_yaw_reg    <= s_tdata[179:148];
                sp_height_reg <= s_tdata[211:180];
                integral_reg  <= '0;
                last_err_reg  <= '0;
                first_reg     <= 1'b1;
            end
            if ((state_reg == ST_MUL_IE) && mul_sts.done)
                integral_reg <= sat48(ACC_W'(integral_reg) + ACC_W'(mul_q16));
            if (state_reg == ST_FINISH)
            begin
                integral_reg <= int_after;
                last_err_reg <= e_reg;
                first_reg    <= 1'b0;
            end
            // Hold the result until the downstream transfer
            if ((state_reg == ST_OUT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Working values of the update in progress
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg  <= sat32(ACC_W'(in_meas_height) - ACC_W'(sp_height_reg));
            dt_reg <= in_dt;
        end
        if ((state_reg == ST_MUL_YAW) && mul_sts.done)
            yaw_cmd_reg <= yaw_clamped;
        if ((state_reg == ST_MUL_IE) && mul_sts.done)
        begin
            d_reg   <= '0;
            neg_reg <= err_diff[32];
        end
        if ((state_reg == ST_DIV) && div_sts.done)
            d_reg <= sat32(ACC_W'(d_signed));
        if ((state_reg == ST_MUL_KP) && mul_sts.done)
            acc_reg <= ACC_W'({1'b0, hover_reg}) + ACC_W'(mul_q16);
        if (((state_reg == ST_MUL_KI) || (state_reg == ST_MUL_KD)) && mul_sts.done)
            acc_reg <= acc_reg + ACC_W'(mul_q16);
        if (state_reg == ST_FINISH)
            thr_reg <= thr;
        if ((state_reg == ST_OUT) && out_free)
            m_tdata_reg <= {7'b0, thr_reg, yaw_cmd_reg, sp_roll_reg, sp_pitch_reg};
    end

    yph_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_prod),
        .sts     (mul_sts)
    );

    yph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dt_reg),
        .quo   (div_quo),
        .sts   (div_sts)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // The multiplier and divider never run together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider busy together");

    // A new result appears only from the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output stage");

    // The throttle never leaves 0..1
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[112:96] <= THR_ONE)
        else $error("throttle out of range");

    // A set-goal transfer leaves the block idle with the first-step flag set and the integral cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == CMD_SET_GOAL)) |=>
            (state_reg == ST_IDLE) && first_reg && (integral_reg == '0))
        else $error("set goal did not reset the loop");

endmodule
